[rtl/ipv4bl_pkg.sv]
// Shared types, codes and constants of the IPv4 source prefix blocklist.
package ipv4bl_pkg;

  localparam int RULE_SLOTS_DEFAULT = 16;
  // slot_index is four bits wide, so no more than this many slots can be written
  localparam int ADDRESSABLE_SLOTS  = 16;
  localparam int COUNTER_COUNT      = 16;
  localparam int CIDX_W             = 4;
  localparam int LEN_W              = 6;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [15:0]      ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [15:0]      ETH_HEADER_BYTES = 16'd14;
  localparam logic [15:0]      IPV4_MIN_BYTES   = 16'd34;
  localparam logic [LEN_W-1:0] MAX_PREFIX       = 6'd32;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_WRITE    = 2'd1,
    OP_READ     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_DROP  = 2'd1,
    VERDICT_ABORT = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    JOB_FIXED = 2'd0,
    JOB_HIT   = 2'd1,
    JOB_READ  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    verdict_t          verdict;
    logic [CIDX_W-1:0] cidx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [31:0] ones;
    ones = 32'hFFFF_FFFF;
    // len of 0 gives no bits, len of 32 gives all bits
    return ~(ones >> len);
  endfunction

endpackage

[rtl/ipv4_source_prefix_blocklist_top.sv]
// Top level of the IPv4 source prefix blocklist classifier.
// An item is taken when start is high and busy is low; the cycle
// after a beat is taken, busy stays high while the front end resolves the longest prefix match
// over the registered match vector of all rule slots. Each item gives exactly one result beat,
// marked by out_valid for a single cycle, after passing through the match resolve register, the
// head of the job queue and the counter update into the output register. Results cannot be held
// off; the back end drains the job queue every cycle. Classify beats check length and
// EtherType, then match the source against the rule table, dropping on a hit and bumping that
// rule's wrapping 64-bit counter; write beats store a rule slot, read beats return a counter.
// Rules and counters are cleared by reset, with no clearing pass.
module ipv4_source_prefix_blocklist_top #(
  parameter int RULE_SLOTS = ipv4bl_pkg::RULE_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_frame_length,
  input  logic [15:0] in_ether_type,
  input  logic [31:0] in_source_address,
  input  logic [3:0]  in_slot_index,
  input  logic [31:0] in_prefix_value,
  input  logic [5:0]  in_prefix_length,
  input  logic [3:0]  in_rule_number,
  input  logic        in_rule_enable,
  output logic        out_valid,
  output logic [1:0]  out_verdict,
  output logic        out_rule_hit,
  output logic [3:0]  out_hit_rule_number,
  output logic [63:0] out_counter_value
);

  ipv4bl_pkg::q_status_t q_status;
  ipv4bl_pkg::job_t      push_job;
  ipv4bl_pkg::job_t      head_job;
  logic                  push;
  logic                  pop;

  ipv4bl_front #(
    .RULE_SLOTS(RULE_SLOTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_frame_length  (in_frame_length),
    .in_ether_type    (in_ether_type),
    .in_source_address(in_source_address),
    .in_slot_index    (in_slot_index),
    .in_prefix_value  (in_prefix_value),
    .in_prefix_length (in_prefix_length),
    .in_rule_number   (in_rule_number),
    .in_rule_enable   (in_rule_enable),
    .q_status_i       (q_status),
    .push_o           (push),
    .job_o            (push_job)
  );

  ipv4bl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_i   (push_job),
    .pop     (pop),
    .job_o   (head_job),
    .status_o(q_status)
  );

  ipv4bl_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_i              (head_job),
    .q_status_i         (q_status),
    .pop_o              (pop),
    .out_valid          (out_valid),
    .out_verdict        (out_verdict),
    .out_rule_hit       (out_rule_hit),
    .out_hit_rule_number(out_hit_rule_number),
    .out_counter_value  (out_counter_value)
  );

endmodule

[rtl/ipv4bl_front.sv]
// Front end: accepts items, holds the rule table and resolves the longest prefix match.
module ipv4bl_front #(
  parameter int RULE_SLOTS = ipv4bl_pkg::RULE_SLOTS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  logic [15:0]           in_frame_length,
  input  logic [15:0]           in_ether_type,
  input  logic [31:0]           in_source_address,
  input  logic [3:0]            in_slot_index,
  input  logic [31:0]           in_prefix_value,
  input  logic [5:0]            in_prefix_length,
  input  logic [3:0]            in_rule_number,
  input  logic                  in_rule_enable,
  input  ipv4bl_pkg::q_status_t q_status_i,
  output logic                  push_o,
  output ipv4bl_pkg::job_t      job_o
);

  localparam int SLOTS = (RULE_SLOTS < ipv4bl_pkg::ADDRESSABLE_SLOTS) ?
                         RULE_SLOTS : ipv4bl_pkg::ADDRESSABLE_SLOTS;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TREE  = 1 << IDX_W;
  localparam int LEN_W = ipv4bl_pkg::LEN_W;

  logic                          slot_valid_r [SLOTS];
  logic [31:0]                   slot_prefix_r [SLOTS];
  logic [LEN_W-1:0]              slot_len_r [SLOTS];
  logic [ipv4bl_pkg::CIDX_W-1:0] slot_cidx_r [SLOTS];

  logic             s1_valid_r;
  logic             s1_lookup_r;
  logic             s1_lookup_nxt;
  ipv4bl_pkg::job_t s1_job_r;
  ipv4bl_pkg::job_t s1_job_nxt;
  logic [SLOTS-1:0] s1_match_r;
  logic [SLOTS-1:0] s1_match_nxt;

  logic             accept;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [LEN_W-1:0] plen_sat;

  logic             node_found [2*TREE];
  logic [LEN_W-1:0] node_len [2*TREE];
  logic [IDX_W-1:0] node_idx [2*TREE];

  // a second item waits while the match vector of the first is being resolved
  assign busy   = s1_valid_r || q_status_i.full;
  assign accept = start && !busy;

  assign wr_en    = accept && (ipv4bl_pkg::op_t'(in_operation) == ipv4bl_pkg::OP_WRITE) &&
                    (int'(in_slot_index) < SLOTS);
  assign wr_idx   = in_slot_index[IDX_W-1:0];
  assign plen_sat = (in_prefix_length > ipv4bl_pkg::MAX_PREFIX) ?
                    ipv4bl_pkg::MAX_PREFIX : in_prefix_length;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      s1_match_nxt[i] = slot_valid_r[i] &&
        (((in_source_address ^ slot_prefix_r[i]) &
          ipv4bl_pkg::prefix_mask(slot_len_r[i])) == 32'd0);
    end
  end

  always_comb begin
    s1_lookup_nxt      = 1'b0;
    s1_job_nxt.kind    = ipv4bl_pkg::JOB_FIXED;
    s1_job_nxt.verdict = ipv4bl_pkg::VERDICT_PASS;
    s1_job_nxt.cidx    = '0;
    case (ipv4bl_pkg::op_t'(in_operation))
      ipv4bl_pkg::OP_CLASSIFY: begin
        if (in_frame_length < ipv4bl_pkg::ETH_HEADER_BYTES) begin
          s1_job_nxt.verdict = ipv4bl_pkg::VERDICT_ABORT;
        end else if (in_ether_type != ipv4bl_pkg::ETHERTYPE_IPV4) begin
          s1_job_nxt.verdict = ipv4bl_pkg::VERDICT_DROP;
        end else if (in_frame_length < ipv4bl_pkg::IPV4_MIN_BYTES) begin
          s1_job_nxt.verdict = ipv4bl_pkg::VERDICT_ABORT;
        end else begin
          s1_lookup_nxt = 1'b1;
        end
      end
      ipv4bl_pkg::OP_READ: begin
        s1_job_nxt.kind = ipv4bl_pkg::JOB_READ;
        s1_job_nxt.cidx = in_rule_number;
      end
      default: begin
      end
    endcase
  end

  // longest length wins; on a tie the left, lower-numbered side is kept
  always_comb begin
    for (int n = 0; n < 2*TREE; n++) begin
      node_found[n] = 1'b0;
      node_len[n]   = '0;
      node_idx[n]   = '0;
    end
    for (int i = 0; i < TREE; i++) begin
      node_idx[TREE+i] = IDX_W'(i);
      if (i < SLOTS) begin
        node_found[TREE+i] = s1_match_r[i];
        node_len[TREE+i]   = slot_len_r[i];
      end
    end
    for (int n = TREE-1; n >= 1; n--) begin
      if (node_found[2*n+1] && (!node_found[2*n] || (node_len[2*n+1] > node_len[2*n]))) begin
        node_found[n] = 1'b1;
        node_len[n]   = node_len[2*n+1];
        node_idx[n]   = node_idx[2*n+1];
      end else begin
        node_found[n] = node_found[2*n];
        node_len[n]   = node_len[2*n];
        node_idx[n]   = node_idx[2*n];
      end
    end
  end

  always_comb begin
    job_o = s1_job_r;
    if (s1_lookup_r) begin
      job_o.verdict = ipv4bl_pkg::VERDICT_PASS;
      job_o.cidx    = '0;
      if (node_found[1]) begin
        job_o.kind    = ipv4bl_pkg::JOB_HIT;
        job_o.verdict = ipv4bl_pkg::VERDICT_DROP;
        job_o.cidx    = slot_cidx_r[node_idx[1]];
      end else begin
        job_o.kind    = ipv4bl_pkg::JOB_FIXED;
      end
    end
  end

  assign push_o = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid_r[i] <= 1'b0;
      end
    end else begin
      s1_valid_r <= accept;
      if (wr_en) begin
        slot_valid_r[wr_idx] <= in_rule_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lookup_r <= s1_lookup_nxt;
      s1_job_r    <= s1_job_nxt;
      s1_match_r  <= s1_match_nxt;
    end
    if (wr_en) begin
      slot_prefix_r[wr_idx] <= in_prefix_value;
      slot_len_r[wr_idx]    <= plen_sat;
      slot_cidx_r[wr_idx]   <= in_rule_number;
    end
  end

endmodule

[rtl/ipv4bl_queue.sv]
// Short job queue between the front end and the counter back end.
module ipv4bl_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ipv4bl_pkg::job_t      job_i,
  input  logic                  pop,
  output ipv4bl_pkg::job_t      job_o,
  output ipv4bl_pkg::q_status_t status_o
);

  localparam int DEPTH = ipv4bl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipv4bl_pkg::job_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign status_o.full  = (count_r == CNT_W'(DEPTH));
  assign status_o.empty = (count_r == '0);
  assign do_pop         = pop && !status_o.empty;
  assign do_push        = push;
  assign job_o          = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && status_o.full |-> do_pop)
    else $error("job pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !do_pop |=> !status_o.empty)
    else $error("pushed job not held in queue");

endmodule

[rtl/ipv4bl_back.sv]
// Back end: hit counters, counter read and the registered result beat.
module ipv4bl_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipv4bl_pkg::job_t      job_i,
  input  ipv4bl_pkg::q_status_t q_status_i,
  output logic                  pop_o,
  output logic                  out_valid,
  output logic [1:0]            out_verdict,
  output logic                  out_rule_hit,
  output logic [3:0]            out_hit_rule_number,
  output logic [63:0]           out_counter_value
);

  logic [63:0] counters_r [ipv4bl_pkg::COUNTER_COUNT];
  logic [63:0] count_inc;
  logic        cnt_we;

  logic        out_valid_r;
  logic [1:0]  out_verdict_r;
  logic [1:0]  out_verdict_nxt;
  logic        out_rule_hit_r;
  logic        out_rule_hit_nxt;
  logic [3:0]  out_hit_rule_number_r;
  logic [3:0]  out_hit_rule_number_nxt;
  logic [63:0] out_counter_value_r;
  logic [63:0] out_counter_value_nxt;

  // the receiver never stalls, so drain one job every cycle
  assign pop_o     = !q_status_i.empty;
  assign count_inc = counters_r[job_i.cidx] + 64'd1;

  always_comb begin
    cnt_we                  = 1'b0;
    out_verdict_nxt         = ipv4bl_pkg::VERDICT_PASS;
    out_rule_hit_nxt        = 1'b0;
    out_hit_rule_number_nxt = '0;
    out_counter_value_nxt   = '0;
    case (job_i.kind)
      ipv4bl_pkg::JOB_HIT: begin
        cnt_we                  = pop_o;
        out_verdict_nxt         = ipv4bl_pkg::VERDICT_DROP;
        out_rule_hit_nxt        = 1'b1;
        out_hit_rule_number_nxt = job_i.cidx;
        out_counter_value_nxt   = count_inc;
      end
      ipv4bl_pkg::JOB_READ: begin
        out_counter_value_nxt = counters_r[job_i.cidx];
      end
      ipv4bl_pkg::JOB_FIXED: begin
        out_verdict_nxt = job_i.verdict;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < ipv4bl_pkg::COUNTER_COUNT; i++) begin
        counters_r[i] <= '0;
      end
    end else begin
      out_valid_r <= pop_o;
      if (cnt_we) begin
        counters_r[job_i.cidx] <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      out_verdict_r         <= out_verdict_nxt;
      out_rule_hit_r        <= out_rule_hit_nxt;
      out_hit_rule_number_r <= out_hit_rule_number_nxt;
      out_counter_value_r   <= out_counter_value_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_verdict         = out_verdict_r;
  assign out_rule_hit        = out_rule_hit_r;
  assign out_hit_rule_number = out_hit_rule_number_r;
  assign out_counter_value   = out_counter_value_r;

endmodule

[verif/tb_ipv4_source_prefix_blocklist_top.sv]
// Testbench for the IPv4 source prefix blocklist: directed table, then random beats vs a predictor.
module tb_ipv4_source_prefix_blocklist_top;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_BEATS = 1950;
  localparam int         STEADY_TAIL  = 300;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] flen;
    logic [15:0] etype;
    logic [31:0] src;
    logic [3:0]  slot;
    logic [31:0] pval;
    logic [5:0]  plen;
    logic [3:0]  rnum;
    logic        en;
  } beat_t;

  typedef struct packed {
    ipv4bl_pkg::verdict_t verdict;
    logic                 hit;
    logic [3:0]           rnum;
    logic [63:0]          count;
  } verdict_rec_t;

  typedef struct packed {
    beat_t        beat;
    logic         pinned;
    verdict_rec_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [15:0] in_frame_length;
  logic [15:0] in_ether_type;
  logic [31:0] in_source_address;
  logic [3:0]  in_slot_index;
  logic [31:0] in_prefix_value;
  logic [5:0]  in_prefix_length;
  logic [3:0]  in_rule_number;
  logic        in_rule_enable;
  logic        out_valid;
  logic [1:0]  out_verdict;
  logic        out_rule_hit;
  logic [3:0]  out_hit_rule_number;
  logic [63:0] out_counter_value;

  // predictor copy of the rule table and the hit counters
  logic        rule_valid [16];
  logic [31:0] rule_prefix [16];
  logic [5:0]  rule_len [16];
  logic [3:0]  rule_cidx [16];
  logic [63:0] hit_count [ipv4bl_pkg::COUNTER_COUNT];

  verdict_rec_t pending_verdicts[$];
  row_t         directed_rows[$];
  verdict_rec_t got;
  int           errors = 0;
  int           cycles = 0;

  ipv4_source_prefix_blocklist_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_frame_length     (in_frame_length),
    .in_ether_type       (in_ether_type),
    .in_source_address   (in_source_address),
    .in_slot_index       (in_slot_index),
    .in_prefix_value     (in_prefix_value),
    .in_prefix_length    (in_prefix_length),
    .in_rule_number      (in_rule_number),
    .in_rule_enable      (in_rule_enable),
    .out_valid           (out_valid),
    .out_verdict         (out_verdict),
    .out_rule_hit        (out_rule_hit),
    .out_hit_rule_number (out_hit_rule_number),
    .out_counter_value   (out_counter_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] match_mask(input logic [5:0] len);
    if (len == 6'd0) return 32'h0;
    if (len >= 6'd32) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF << (6'd32 - len);
  endfunction

  // Advance the predictor by one accepted beat and return the result it causes.
  function automatic verdict_rec_t predict_verdict(input beat_t b);
    verdict_rec_t r;
    int           best;
    logic [5:0]   best_len;
    logic [5:0]   len;
    r = '0;
    best = -1;
    best_len = '0;
    case (b.op)
      ipv4bl_pkg::OP_CLASSIFY: begin
        if (b.flen < ipv4bl_pkg::ETH_HEADER_BYTES) begin
          r.verdict = ipv4bl_pkg::VERDICT_ABORT;
        end else if (b.etype != ipv4bl_pkg::ETHERTYPE_IPV4) begin
          r.verdict = ipv4bl_pkg::VERDICT_DROP;
        end else if (b.flen < ipv4bl_pkg::IPV4_MIN_BYTES) begin
          r.verdict = ipv4bl_pkg::VERDICT_ABORT;
        end else begin
          for (int i = 0; i < 16; i++) begin
            if (rule_valid[i] && ((b.src ^ rule_prefix[i]) & match_mask(rule_len[i])) == 32'h0
                && (best < 0 || rule_len[i] > best_len)) begin
              best = i;
              best_len = rule_len[i];
            end
          end
          if (best >= 0) begin
            hit_count[rule_cidx[best]] = hit_count[rule_cidx[best]] + 64'd1;
            r.verdict = ipv4bl_pkg::VERDICT_DROP;
            r.hit = 1'b1;
            r.rnum = rule_cidx[best];
            r.count = hit_count[rule_cidx[best]];
          end
        end
      end
      ipv4bl_pkg::OP_WRITE: begin
        len = (b.plen > ipv4bl_pkg::MAX_PREFIX) ? ipv4bl_pkg::MAX_PREFIX : b.plen;
        rule_valid[b.slot] = b.en;
        rule_prefix[b.slot] = b.pval;
        rule_len[b.slot] = len;
        rule_cidx[b.slot] = b.rnum;
      end
      ipv4bl_pkg::OP_READ: r.count = hit_count[b.rnum];
      default: ;
    endcase
    return r;
  endfunction

  // Fields a beat does not use are filled with noise.
  function automatic beat_t noise_beat(input logic [1:0] op);
    beat_t b;
    b.op = op;
    b.flen = 16'($urandom);
    b.etype = 16'($urandom);
    b.src = $urandom;
    b.slot = 4'($urandom);
    b.pval = $urandom;
    b.plen = 6'($urandom);
    b.rnum = 4'($urandom);
    b.en = 1'($urandom);
    return b;
  endfunction

  function automatic beat_t classify_beat(input logic [15:0] flen, input logic [15:0] etype,
                                          input logic [31:0] src);
    beat_t b;
    b = noise_beat(ipv4bl_pkg::OP_CLASSIFY);
    b.flen = flen;
    b.etype = etype;
    b.src = src;
    return b;
  endfunction

  function automatic beat_t rule_write_beat(input logic [3:0] slot, input logic [31:0] pval,
                                            input logic [5:0] plen, input logic [3:0] rnum,
                                            input logic en);
    beat_t b;
    b = noise_beat(ipv4bl_pkg::OP_WRITE);
    b.slot = slot;
    b.pval = pval;
    b.plen = plen;
    b.rnum = rnum;
    b.en = en;
    return b;
  endfunction

  function automatic beat_t counter_read_beat(input logic [3:0] rnum);
    beat_t b;
    b = noise_beat(ipv4bl_pkg::OP_READ);
    b.rnum = rnum;
    return b;
  endfunction

  function automatic verdict_rec_t result(input ipv4bl_pkg::verdict_t v, input logic hit,
                                          input logic [3:0] rnum, input logic [63:0] count);
    verdict_rec_t r;
    r.verdict = v;
    r.hit = hit;
    r.rnum = rnum;
    r.count = count;
    return r;
  endfunction

  function automatic beat_t random_beat();
    int          k;
    int          j;
    logic [5:0]  plen;
    logic [15:0] etype;
    logic [31:0] src;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      case ($urandom_range(0, 9))
        0: begin
          etype = $urandom_range(0, 1) ? ipv4bl_pkg::ETHERTYPE_IPV4 : 16'($urandom);
          return classify_beat(16'($urandom_range(0, 33)), etype, $urandom);
        end
        1: return classify_beat(16'($urandom), 16'($urandom), $urandom);
        default: begin
          // aim most sources inside a stored prefix so that hits are frequent
          j = $urandom_range(0, 15);
          src = $urandom;
          if ($urandom_range(0, 9) < 7)
            src = rule_prefix[j] ^ (src & ~match_mask(rule_len[j]));
          return classify_beat(16'($urandom_range(34, 65535)),
                               ipv4bl_pkg::ETHERTYPE_IPV4, src);
        end
      endcase
    end else if (k < 80) begin
      if ($urandom_range(0, 9) == 0)
        plen = 6'($urandom_range(33, 63));
      else if ($urandom_range(0, 19) == 0)
        plen = 6'd0;
      else
        plen = 6'($urandom_range(1, 32));
      return rule_write_beat(4'($urandom), $urandom, plen, 4'($urandom),
                             $urandom_range(0, 5) != 0);
    end else if (k < 95) begin
      return counter_read_beat(4'($urandom));
    end
    return noise_beat(OP_UNUSED);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] act);
    if (want !== act) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, act);
      errors++;
    end
  endtask

  // Drive one beat from the falling edge and hold it until accepted.
  task automatic send_beat(input beat_t b, input logic pinned, input verdict_rec_t want);
    verdict_rec_t r;
    @(negedge clk);
    start = 1'b1;
    in_operation = b.op;
    in_frame_length = b.flen;
    in_ether_type = b.etype;
    in_source_address = b.src;
    in_slot_index = b.slot;
    in_prefix_value = b.pval;
    in_prefix_length = b.plen;
    in_rule_number = b.rnum;
    in_rule_enable = b.en;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_verdict(b);
    pending_verdicts.push_back(pinned ? want : r);
  endtask

  // Drop start for a burst, with junk on the payload.
  task automatic rest(input int n);
    beat_t b;
    b = noise_beat(2'($urandom));
    @(negedge clk);
    start = 1'b0;
    in_operation = b.op;
    in_frame_length = b.flen;
    in_ether_type = b.etype;
    in_source_address = b.src;
    in_slot_index = b.slot;
    in_prefix_value = b.pval;
    in_prefix_length = b.plen;
    in_rule_number = b.rnum;
    in_rule_enable = b.en;
    repeat (n - 1) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        got = pending_verdicts.pop_front();
        check_field("verdict", 64'(got.verdict), 64'(out_verdict));
        check_field("rule_hit", 64'(got.hit), 64'(out_rule_hit));
        check_field("hit_rule_number", 64'(got.rnum), 64'(out_hit_rule_number));
        check_field("counter_value", got.count, out_counter_value);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = '0;
    in_frame_length = '0;
    in_ether_type = '0;
    in_source_address = '0;
    in_slot_index = '0;
    in_prefix_value = '0;
    in_prefix_length = '0;
    in_rule_number = '0;
    in_rule_enable = 1'b0;
    for (int i = 0; i < 16; i++) begin
      rule_valid[i] = 1'b0;
      rule_prefix[i] = '0;
      rule_len[i] = '0;
      rule_cidx[i] = '0;
      hit_count[i] = '0;
    end

    // reset state, length and EtherType boundaries
    directed_rows.push_back('{counter_read_beat(4'd0), 1'b1, '0});
    directed_rows.push_back('{classify_beat(16'd0, ipv4bl_pkg::ETHERTYPE_IPV4, 32'h0), 1'b1,
                              result(ipv4bl_pkg::VERDICT_ABORT, 1'b0, 4'd0, 64'd0)});
    directed_rows.push_back('{classify_beat(16'd13, ipv4bl_pkg::ETHERTYPE_IPV4, 32'hFFFF_FFFF),
                              1'b1, result(ipv4bl_pkg::VERDICT_ABORT, 1'b0, 4'd0, 64'd0)});
    directed_rows.push_back('{classify_beat(16'd14, 16'h86DD, 32'h0A00_0001), 1'b1,
                              result(ipv4bl_pkg::VERDICT_DROP, 1'b0, 4'd0, 64'd0)});
    directed_rows.push_back('{classify_beat(16'd33, ipv4bl_pkg::ETHERTYPE_IPV4, 32'h0A00_0001),
                              1'b1, result(ipv4bl_pkg::VERDICT_ABORT, 1'b0, 4'd0, 64'd0)});
    directed_rows.push_back('{classify_beat(16'd34, ipv4bl_pkg::ETHERTYPE_IPV4, 32'h0), 1'b1,
                              '0});
    directed_rows.push_back('{classify_beat(16'hFFFF, ipv4bl_pkg::ETHERTYPE_IPV4, 32'hFFFF_FFFF),
                              1'b1, '0});
    directed_rows.push_back('{classify_beat(16'hFFFF, 16'h0000, 32'h0), 1'b1,
                              result(ipv4bl_pkg::VERDICT_DROP, 1'b0, 4'd0, 64'd0)});
    directed_rows.push_back('{classify_beat(16'hFFFF, 16'hFFFF, 32'h0), 1'b1,
                              result(ipv4bl_pkg::VERDICT_DROP, 1'b0, 4'd0, 64'd0)});
    // catch-all rule, then nested prefixes, saturation and ties
    directed_rows.push_back('{rule_write_beat(4'd0, 32'hDEAD_BEEF, 6'd0, 4'd3, 1'b1), 1'b1, '0});
    directed_rows.push_back('{classify_beat(16'd64, ipv4bl_pkg::ETHERTYPE_IPV4, 32'h1234_5678),
                              1'b0, '0});
    directed_rows.push_back('{rule_write_beat(4'd5, 32'hC0A8_00FF, 6'd16, 4'd7, 1'b1), 1'b1, '0});
    directed_rows.push_back('{rule_write_beat(4'd2, 32'hC0A8_0100, 6'd24, 4'd9, 1'b1), 1'b1, '0});
    directed_rows.push_back('{classify_beat(16'd1500, ipv4bl_pkg::ETHERTYPE_IPV4, 32'hC0A8_0105),
                              1'b0, '0});
    directed_rows.push_back('{classify_beat(16'd1500, ipv4bl_pkg::ETHERTYPE_IPV4, 32'hC0A8_0205),
                              1'b0, '0});
    directed_rows.push_back('{rule_write_beat(4'd15, 32'hFFFF_FFFF, 6'd63, 4'd15, 1'b1), 1'b1,
                              '0});
    directed_rows.push_back('{classify_beat(16'd34, ipv4bl_pkg::ETHERTYPE_IPV4, 32'hFFFF_FFFF),
                              1'b0, '0});
    directed_rows.push_back('{classify_beat(16'd34, ipv4bl_pkg::ETHERTYPE_IPV4, 32'hFFFF_FFFE),
                              1'b0, '0});
    directed_rows.push_back('{rule_write_beat(4'd3, 32'hC0A8_01FF, 6'd24, 4'd1, 1'b1), 1'b1, '0});
    directed_rows.push_back('{classify_beat(16'd100, ipv4bl_pkg::ETHERTYPE_IPV4, 32'hC0A8_0142),
                              1'b0, '0});
    directed_rows.push_back('{rule_write_beat(4'd2, 32'h0, 6'd0, 4'd0, 1'b0), 1'b1, '0});
    directed_rows.push_back('{classify_beat(16'd100, ipv4bl_pkg::ETHERTYPE_IPV4, 32'hC0A8_0142),
                              1'b0, '0});
    directed_rows.push_back('{noise_beat(OP_UNUSED), 1'b1, '0});
    directed_rows.push_back('{counter_read_beat(4'd3), 1'b0, '0});
    directed_rows.push_back('{counter_read_beat(4'd15), 1'b0, '0});
    directed_rows.push_back('{rule_write_beat(4'd0, 32'h0, 6'd0, 4'd3, 1'b0), 1'b1, '0});
    directed_rows.push_back('{classify_beat(16'd34, ipv4bl_pkg::ETHERTYPE_IPV4, 32'h0A00_0001),
                              1'b0, '0});

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 3) == 0) rest($urandom_range(1, 14));
      send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].want);
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i < RANDOM_BEATS - STEADY_TAIL && $urandom_range(0, 4) == 0)
        rest($urandom_range(1, 14));
      send_beat(random_beat(), 1'b0, '0);
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_verdicts.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/ipv4bl_pkg.sv
rtl/ipv4bl_front.sv
rtl/ipv4bl_queue.sv
rtl/ipv4bl_back.sv
rtl/ipv4_source_prefix_blocklist_top.sv
verif/tb_ipv4_source_prefix_blocklist_top.sv
